FILE: rtl/core/bsa_pkg.sv
`default_nettype none

package bsa_pkg;

    localparam int VALUE_W  = 32;
    localparam int DIGIT_W  = 4;
    localparam int BCD_W    = 24;
    localparam int BIN_W    = 20;
    localparam int DEC_BASE = 10;
    localparam int DABBLE_LIMIT = 5;
    localparam int DABBLE_ADJ   = 3;

    // what one digit cell does on the next edge
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_CLEAR,
        CELL_DABBLE,
        CELL_SHIFT
    } cell_op_t;

endpackage

`default_nettype wire

FILE: rtl/core/bsa_digit_cell.sv
`default_nettype none

module bsa_digit_cell (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire bsa_pkg::cell_op_t             op,
    input  wire logic                          cin,
    input  wire logic [bsa_pkg::DIGIT_W-1:0]   din,
    output logic      [bsa_pkg::DIGIT_W-1:0]   digit,
    output logic                               cout
);

    logic [bsa_pkg::DIGIT_W-1:0] digit_reg;
    logic [bsa_pkg::DIGIT_W-1:0] digit_next;
    logic [bsa_pkg::DIGIT_W-1:0] adj;

    // add-3 correction so that the doubling carries in decimal
    always_comb
    begin
        if (digit_reg >= bsa_pkg::DIGIT_W'(bsa_pkg::DABBLE_LIMIT))
        begin
            adj = digit_reg + bsa_pkg::DIGIT_W'(bsa_pkg::DABBLE_ADJ);
        end
        else
        begin
            adj = digit_reg;
        end
    end

    always_comb
    begin
        case (op)
            bsa_pkg::CELL_CLEAR:  digit_next = '0;
            bsa_pkg::CELL_DABBLE: digit_next = {adj[bsa_pkg::DIGIT_W-2:0], cin};
            bsa_pkg::CELL_SHIFT:  digit_next = din;
            default:              digit_next = digit_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg <= '0;
        end
        else
        begin
            digit_reg <= digit_next;
        end
    end

    assign digit = digit_reg;
    assign cout  = adj[bsa_pkg::DIGIT_W-1];

endmodule

`default_nettype wire

FILE: rtl/core/bsa_bcd_adder.sv
`default_nettype none

module bsa_bcd_adder (
    input  wire logic [bsa_pkg::DIGIT_W-1:0] a,
    input  wire logic [bsa_pkg::DIGIT_W-1:0] b,
    input  wire logic                        cin,
    input  wire logic                        load,
    output logic      [bsa_pkg::DIGIT_W-1:0] sum,
    output logic                             cout
);

    logic [bsa_pkg::DIGIT_W:0] raw;
    logic [bsa_pkg::DIGIT_W:0] wrapped;
    logic                      ge;

    assign raw     = {1'b0, a} + {1'b0, b} + {{bsa_pkg::DIGIT_W{1'b0}}, cin};
    assign ge      = raw >= (bsa_pkg::DIGIT_W + 1)'(bsa_pkg::DEC_BASE);
    assign wrapped = raw - (bsa_pkg::DIGIT_W + 1)'(bsa_pkg::DEC_BASE);

    always_comb
    begin
        if (load)
        begin
            sum = b;
        end
        else if (ge)
        begin
            sum = wrapped[bsa_pkg::DIGIT_W-1:0];
        end
        else
        begin
            sum = raw[bsa_pkg::DIGIT_W-1:0];
        end
    end

    assign cout = ge & ~load;

endmodule

`default_nettype wire

FILE: rtl/core/bcd_score_accumulator.sv
`default_nettype none

// Six-digit (NUM_DIGITS) packed BCD running total. Each input word carries a 32-bit
// binary value in tdata and a command in tuser (0 adds, 1 loads); only the value's low
// NUM_DIGITS decimal digits count, and an add wraps past the top digit. Every input word
// yields one output word with the new total in packed BCD and in binary. An item goes
// through an accept step, 32 double-dabble steps through the operand digit cells, one
// digit-add step per digit as both cell rows shift past a single BCD adder and a hand-off
// step to the output register. The hand-off waits for as long as the previous output word
// is still unaccepted. The input is taken again while a finished word still waits at the
// output.
module bcd_score_accumulator #(
    parameter int NUM_DIGITS = 6
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // value
    input  wire logic        s_axis_tuser,  // cmd
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [47:0] m_axis_tdata   // total_bcd, total_binary, zero pad
);

    localparam int DW    = bsa_pkg::DIGIT_W;
    localparam int TOT_W = DW * NUM_DIGITS;
    localparam int CNT_W = $clog2(bsa_pkg::VALUE_W);
    localparam int PAD_W = 48 - bsa_pkg::BCD_W - bsa_pkg::BIN_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_ADD,
        ST_DONE
    } state_t;

    state_t                        state_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic [bsa_pkg::VALUE_W-1:0]   value_reg;
    logic                          cmd_reg;
    logic                          carry_reg;
    logic [bsa_pkg::BIN_W-1:0]     bin_reg;
    logic [bsa_pkg::BIN_W-1:0]     weight_reg;
    logic                          m_valid_reg;
    logic [47:0]                   m_data_reg;

    bsa_pkg::cell_op_t             opd_op;
    bsa_pkg::cell_op_t             tot_op;
    logic [DW-1:0]                 opd_digit [NUM_DIGITS];
    logic [DW-1:0]                 tot_digit [NUM_DIGITS];
    logic                          opd_carry [NUM_DIGITS];
    logic                          tot_carry [NUM_DIGITS];
    logic [TOT_W-1:0]              tot_vec;
    logic [bsa_pkg::BCD_W-1:0]     tot_bcd;
    logic [DW-1:0]                 sum_digit;
    logic                          sum_carry;
    logic [bsa_pkg::BIN_W+DW-1:0]  prod;
    logic                          in_fire;
    logic                          out_free;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_free = !m_valid_reg || m_axis_tready;

    always_comb
    begin
        case (state_reg)
            ST_IDLE: opd_op = in_fire ? bsa_pkg::CELL_CLEAR : bsa_pkg::CELL_HOLD;
            ST_CONV: opd_op = bsa_pkg::CELL_DABBLE;
            ST_ADD:  opd_op = bsa_pkg::CELL_SHIFT;
            default: opd_op = bsa_pkg::CELL_HOLD;
        endcase
    end

    assign tot_op = (state_reg == ST_ADD) ? bsa_pkg::CELL_SHIFT : bsa_pkg::CELL_HOLD;

    // operand row: double dabble while converting, shift toward digit 0 while adding
    // total row: shifts toward digit 0, new sum digits enter at the top
    for (genvar i = 0; i < NUM_DIGITS; i++)
    begin : g_cell
        logic          opd_cin;
        logic [DW-1:0] opd_din;
        logic [DW-1:0] tot_din;

        if (i == 0)
        begin : g_low
            assign opd_cin = value_reg[bsa_pkg::VALUE_W-1];
        end
        else
        begin : g_mid
            assign opd_cin = opd_carry[i-1];
        end

        if (i == NUM_DIGITS - 1)
        begin : g_top
            assign opd_din = '0;
            assign tot_din = sum_digit;
        end
        else
        begin : g_rest
            assign opd_din = opd_digit[i+1];
            assign tot_din = tot_digit[i+1];
        end

        bsa_digit_cell u_opd (
            .clk   (clk),
            .rst_n (rst_n),
            .op    (opd_op),
            .cin   (opd_cin),
            .din   (opd_din),
            .digit (opd_digit[i]),
            .cout  (opd_carry[i])
        );

        bsa_digit_cell u_tot (
            .clk   (clk),
            .rst_n (rst_n),
            .op    (tot_op),
            .cin   (1'b0),
            .din   (tot_din),
            .digit (tot_digit[i]),
            .cout  (tot_carry[i])
        );

        assign tot_vec[i*DW +: DW] = tot_digit[i];
    end

    if (TOT_W >= bsa_pkg::BCD_W)
    begin : g_bcd_trunc
        assign tot_bcd = tot_vec[bsa_pkg::BCD_W-1:0];
    end
    else
    begin : g_bcd_ext
        assign tot_bcd = {{(bsa_pkg::BCD_W - TOT_W){1'b0}}, tot_vec};
    end

    bsa_bcd_adder u_adder (
        .a    (tot_digit[0]),
        .b    (opd_digit[0]),
        .cin  (carry_reg),
        .load (cmd_reg),
        .sum  (sum_digit),
        .cout (sum_carry)
    );

    assign prod = {{bsa_pkg::BIN_W{1'b0}}, sum_digit} * {{DW{1'b0}}, weight_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            value_reg   <= '0;
            cmd_reg     <= 1'b0;
            bin_reg     <= '0;
            weight_reg  <= '0;
            m_data_reg  <= '0;
            m_valid_reg <= 1'b0;
            carry_reg   <= 1'b0;
        end
        else
        begin
            // a word leaving while ST_DONE hands off is replaced there
            if (m_valid_reg && m_axis_tready && (state_reg != ST_DONE))
            begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        value_reg <= s_axis_tdata;
                        cmd_reg   <= s_axis_tuser;
                        cnt_reg   <= '0;
                        state_reg <= ST_CONV;
                    end
                end
                ST_CONV:
                begin
                    value_reg <= {value_reg[bsa_pkg::VALUE_W-2:0], 1'b0};
                    if (cnt_reg == CNT_W'(bsa_pkg::VALUE_W - 1))
                    begin
                        cnt_reg    <= '0;
                        carry_reg  <= 1'b0;
                        bin_reg    <= '0;
                        weight_reg <= bsa_pkg::BIN_W'(1);
                        state_reg  <= ST_ADD;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                ST_ADD:
                begin
                    carry_reg  <= sum_carry;
                    bin_reg    <= bin_reg + prod[bsa_pkg::BIN_W-1:0];
                    // weight times ten, wrapping with the binary field
                    weight_reg <= (weight_reg << 3) + (weight_reg << 1);
                    if (cnt_reg == CNT_W'(NUM_DIGITS - 1))
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        m_data_reg  <= {{PAD_W{1'b0}}, bin_reg, tot_bcd};
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    function automatic logic bcd_ok(input logic [bsa_pkg::BCD_W-1:0] v);
        logic ok;
        ok = 1'b1;
        for (int k = 0; k < bsa_pkg::BCD_W / DW; k++)
        begin
            if (v[k*DW +: DW] >= DW'(bsa_pkg::DEC_BASE))
            begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !s_axis_tready)
        else $error("input taken while an item is still being worked");

    a_out_digits_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> bcd_ok(m_axis_tdata[bsa_pkg::BCD_W-1:0]))
        else $error("output total holds a non-decimal digit");

    a_out_binary_range: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && NUM_DIGITS == 6) |->
            (m_axis_tdata[bsa_pkg::BCD_W +: bsa_pkg::BIN_W] <= bsa_pkg::BIN_W'(999999)))
        else $error("binary total out of range");

    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("pending output word overwritten");

endmodule

`default_nettype wire

FILE: tb/bcd_score_accumulator_tb.sv
`default_nettype none

module bcd_score_accumulator_tb;

    localparam int NUM_DIGITS = 6;

    localparam int VALUE_W  = bsa_pkg::VALUE_W;
    localparam int DIGIT_W  = bsa_pkg::DIGIT_W;
    localparam int BCD_W    = bsa_pkg::BCD_W;
    localparam int BIN_W    = bsa_pkg::BIN_W;
    localparam int DEC_BASE = bsa_pkg::DEC_BASE;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    typedef struct packed {
        logic [BIN_W-1:0] bin;
        logic [BCD_W-1:0] bcd;
    } score_t;

    logic               clk;
    logic               rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [VALUE_W-1:0] s_axis_tdata;   // value
    logic               s_axis_tuser;   // cmd
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [47:0]        m_axis_tdata;   // total_bcd, total_binary, zero pad

    score_t             expected_scores[$];
    logic [BCD_W-1:0]   running_total;
    int                 sender_idle_pct;
    int                 receiver_stall_pct;
    int                 error_count;
    int                 words_sent;
    int                 loads_sent;
    int                 words_checked;

    bcd_score_accumulator #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("bcd_score_accumulator_tb NOT OK");
        $finish;
    end

    // keeps only the low decimal digits, which is the modulo reduction
    function automatic logic [BCD_W-1:0] binary_to_digits(input logic [VALUE_W-1:0] v);
        logic [VALUE_W-1:0] rest;
        logic [BCD_W-1:0]   digits;
        rest   = v;
        digits = '0;
        for (int d = 0; d < NUM_DIGITS; d++)
        begin
            digits[d*DIGIT_W +: DIGIT_W] = DIGIT_W'(rest % DEC_BASE);
            rest = rest / DEC_BASE;
        end
        return digits;
    endfunction

    function automatic logic [BCD_W-1:0] digits_add(input logic [BCD_W-1:0] a,
                                                    input logic [BCD_W-1:0] b);
        logic [BCD_W-1:0] sum;
        int               s;
        int               carry;
        sum   = '0;
        carry = 0;
        for (int d = 0; d < NUM_DIGITS; d++)
        begin
            s     = a[d*DIGIT_W +: DIGIT_W] + b[d*DIGIT_W +: DIGIT_W] + carry;
            carry = (s >= DEC_BASE) ? 1 : 0;
            if (carry != 0)
                s = s - DEC_BASE;
            sum[d*DIGIT_W +: DIGIT_W] = DIGIT_W'(s);
        end
        // carry out of the top digit is dropped
        return sum;
    endfunction

    function automatic logic [BIN_W-1:0] digits_to_binary(input logic [BCD_W-1:0] digits);
        int v;
        v = 0;
        for (int d = NUM_DIGITS - 1; d >= 0; d--)
            v = v * DEC_BASE + digits[d*DIGIT_W +: DIGIT_W];
        return BIN_W'(v);
    endfunction

    function automatic void predict_total(input logic cmd, input logic [VALUE_W-1:0] value);
        logic [BCD_W-1:0] operand;
        score_t           score;
        operand = binary_to_digits(value);
        if (cmd == CMD_LOAD)
            running_total = operand;
        else
            running_total = digits_add(running_total, operand);
        score.bcd = running_total;
        score.bin = digits_to_binary(running_total);
        expected_scores.push_back(score);
    endfunction

    function automatic logic [VALUE_W-1:0] random_value();
        logic [VALUE_W-1:0] v;
        case ($urandom_range(5))
            0:       v = $urandom;
            1:       v = $urandom_range(999);
            2:       v = 999999 - $urandom_range(50);
            3:       v = 1000000 * $urandom_range(4294) + $urandom_range(20);
            4:       v = 32'h1 << $urandom_range(31);
            default: v = $urandom_range(999999);
        endcase
        return v;
    endfunction

    task automatic send_word(input logic cmd, input logic [VALUE_W-1:0] value);
        int gap;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= cmd;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_total(cmd, value);
        words_sent++;
        if (cmd == CMD_LOAD)
            loads_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        while (expected_scores.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic test_directed();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        send_word(CMD_ADD,  32'd0);
        send_word(CMD_LOAD, 32'd0);
        send_word(CMD_LOAD, 32'd999999);
        // wraps back to zero
        send_word(CMD_ADD,  32'd1);
        send_word(CMD_LOAD, 32'd999999);
        send_word(CMD_ADD,  32'd999999);
        send_word(CMD_LOAD, 32'hFFFF_FFFF);
        send_word(CMD_ADD,  32'hFFFF_FFFF);
        send_word(CMD_LOAD, 32'd1000000);
        send_word(CMD_ADD,  32'd123456789);
        send_word(CMD_LOAD, 32'd99999);
        // ripple carry through five digits
        send_word(CMD_ADD,  32'd1);
        send_word(CMD_ADD,  32'h8000_0000);
        send_word(CMD_ADD,  32'hAAAA_AAAA);
        send_word(CMD_ADD,  32'h5555_5555);
        send_word(CMD_LOAD, 32'd555555);
        send_word(CMD_ADD,  32'd444445);
        send_word(CMD_ADD,  32'd4294000000);
        send_word(CMD_ADD,  32'd9);
        send_word(CMD_LOAD, 32'd1);
    endtask

    task automatic test_random(input int count, input int idle_pct, input int stall_pct);
        logic cmd;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        for (int i = 0; i < count; i++)
        begin
            cmd = ($urandom_range(99) < 20) ? CMD_LOAD : CMD_ADD;
            send_word(cmd, random_value());
        end
    endtask

    // sender holds off until the output side has caught up, then resumes
    task automatic test_drain_pause();
        sender_idle_pct    = 10;
        receiver_stall_pct = 50;
        for (int round = 0; round < 3; round++)
        begin
            for (int i = 0; i < 6; i++)
                send_word(($urandom_range(3) == 0) ? CMD_LOAD : CMD_ADD, random_value());
            s_axis_tvalid <= 1'b0;
            wait_drained();
        end
    endtask

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_scores.size() == 0)
            begin
                $display("%0t: unexpected word, actual %h", $time, m_axis_tdata);
                error_count++;
            end
            else
            begin
                if (m_axis_tdata[BCD_W-1:0] != expected_scores[0].bcd)
                begin
                    $display("%0t: total_bcd mismatch, expected %h actual %h", $time,
                             expected_scores[0].bcd, m_axis_tdata[BCD_W-1:0]);
                    error_count++;
                end
                if (m_axis_tdata[BCD_W +: BIN_W] != expected_scores[0].bin)
                begin
                    $display("%0t: total_binary mismatch, expected %0d actual %0d", $time,
                             expected_scores[0].bin, m_axis_tdata[BCD_W +: BIN_W]);
                    error_count++;
                end
                void'(expected_scores.pop_front());
                words_checked++;
            end
        end
    end

    initial
    begin
        rst_n              = 1'b0;
        s_axis_tvalid      = 1'b0;
        s_axis_tdata       = '0;
        s_axis_tuser       = CMD_ADD;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        error_count        = 0;
        words_sent         = 0;
        loads_sent         = 0;
        words_checked      = 0;
        running_total      = '0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_random(140, 0, 0);
        test_random(130, 71, 0);
        test_random(130, 0, 71);
        test_drain_pause();
        test_random(130, 32, 32);

        s_axis_tvalid <= 1'b0;
        wait_drained();
        repeat (100) @(posedge clk);
        if (expected_scores.size() != 0)
        begin
            $display("%0t: %0d expected words never arrived", $time, expected_scores.size());
            error_count++;
        end

        $display("sent %0d words (%0d loads), checked %0d totals", words_sent, loads_sent,
                 words_checked);
        $display("covered wrap on add, modulo reduction of wide values, idle and stall mixes");
        if (error_count == 0)
            $display("bcd_score_accumulator_tb OK");
        else
            $display("bcd_score_accumulator_tb NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
